[hdl/ccpb_pkg.sv]
// ----------------------------------------------------------------------------
// ccpb_pkg
// Shared types, constants and kernel helpers for the circle contrast and
// pyramid blur filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpb_pkg;

  localparam int KSIZE_DEF     = 5;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int SAT_MAX       = 255;

  // Register indexes
  localparam logic [2:0] REG_HEIGHT     = 3'd0;
  localparam logic [2:0] REG_WIDTH      = 3'd1;
  localparam logic [2:0] REG_RADIUS     = 3'd2;
  localparam logic [2:0] REG_CONTRAST   = 3'd3;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd4;

  // Register reset values
  localparam logic [12:0] RST_HEIGHT     = 13'd480;
  localparam logic [11:0] RST_WIDTH      = 12'd640;
  localparam logic [12:0] RST_RADIUS     = 13'd0;
  localparam logic [8:0]  RST_CONTRAST   = 9'd1;
  localparam logic [10:0] RST_BRIGHTNESS = 11'd0;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        run_end;
  } pix_out_t;

  // Pyramid weight at window position (a, b)
  function automatic int pyr_weight(input int k, input int a, input int b);
    int m;
    m = a;
    if (b < m) m = b;
    if (k - 1 - a < m) m = k - 1 - a;
    if (k - 1 - b < m) m = k - 1 - b;
    return 1 + m;
  endfunction

  // Sum of all kernel weights
  function automatic int pyr_total(input int k);
    int s;
    s = 0;
    for (int a = 0; a < k; a++) begin
      for (int b = 0; b < k; b++) begin
        s = s + pyr_weight(k, a, b);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/circle_contrast_pyramid_blur.sv]
// A pixel accepted with no burst leaves the input free; a burst passes S_MOD and
// S_SLOT, then per output pixel: a last row or column pixel S_PIX and S_EMIT,
// other black pixels also S_DEC, a circle pixel also S_CAPP, a blurred pixel one
// line-store read per window tap, then a reciprocal multiply; S_EMIT holds while
// the output stalls. One pixel is in work at a time. Synchronous active-low reset
// clears state, counters and config registers, not the datapath or line store.
// ----------------------------------------------------------------------------
// circle_contrast_pyramid_blur
// Streaming filter: contrast/brightness inside a circle, pyramid blur or black outside.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_contrast_pyramid_blur
  import ccpb_pkg::*;
#(
  parameter int KSIZE     = KSIZE_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire pix_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output pix_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int DEPTH     = KSIZE * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int SW        = (KSIZE > 1) ? $clog2(KSIZE) : 1;
  localparam int TOT       = pyr_total(KSIZE);
  localparam int SUMW      = $clog2(SAT_MAX * TOT + 1);
  localparam int TOT_RSH   = 24;
  localparam int TOT_RECIP = ((1 << TOT_RSH) + TOT - 1) / TOT;
  localparam int QPW       = SUMW + TOT_RSH + 1;
  localparam int RECIP     = ((1 << 24) + KSIZE - 1) / KSIZE;
  localparam logic signed [13:0] KS = 14'(KSIZE);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MOD   = 10'b0000000010,
    S_SLOT  = 10'b0000000100,
    S_PIX   = 10'b0000001000,
    S_DEC   = 10'b0000010000,
    S_CAPP  = 10'b0000100000,
    S_BRD   = 10'b0001000000,
    S_BLAST = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic        [12:0] height_r;
  logic        [11:0] width_r;
  logic        [12:0] radius_r;
  logic signed [8:0]  contrast_r;
  logic signed [10:0] bright_r;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r   <= RST_HEIGHT;
      width_r    <= RST_WIDTH;
      radius_r   <= RST_RADIUS;
      contrast_r <= RST_CONTRAST;
      bright_r   <= RST_BRIGHTNESS;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_HEIGHT:     height_r   <= pwdata[12:0];
        REG_WIDTH:      width_r    <= pwdata[11:0];
        REG_RADIUS:     radius_r   <= pwdata[12:0];
        REG_CONTRAST:   contrast_r <= pwdata[8:0];
        REG_BRIGHTNESS: bright_r   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[4:2])
      REG_HEIGHT:     prdata = 32'(height_r);
      REG_WIDTH:      prdata = 32'(width_r);
      REG_RADIUS:     prdata = 32'(radius_r);
      REG_CONTRAST:   prdata = 32'(unsigned'(contrast_r));
      REG_BRIGHTNESS: prdata = 32'(unsigned'(bright_r));
      default:        prdata = 32'd0;
    endcase
  end

  // Clamped geometry
  logic signed [13:0] h_s, w_s;
  always_comb begin
    h_s = 14'(height_r);
    if (h_s < 14'sd2) h_s = 14'sd2;
    if (h_s > 14'sd4096) h_s = 14'sd4096;
    w_s = 14'(width_r);
    if (w_s < 14'sd2) w_s = 14'sd2;
    if (int'(w_s) > MAX_WIDTH) w_s = 14'(MAX_WIDTH);
  end

  // Source position and its line-store slot
  logic [11:0]   row_r;
  logic [10:0]   col_r;
  logic [SW-1:0] slot_r;

  logic               in_acc, last_row, last_col, burst_ok;
  logic signed [13:0] r_s, c_s, i0_c, j0_c;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign r_s      = 14'(row_r);
  assign c_s      = 14'(col_r);
  assign last_row = r_s >= h_s - 14'sd1;
  assign last_col = c_s >= w_s - 14'sd1;

  always_comb begin
    if (last_row) begin
      i0_c = (h_s - KS < 0) ? 14'sd0 : h_s - KS;
    end else begin
      i0_c = r_s - KS + 14'sd1;
    end
    if (last_col) begin
      j0_c = (w_s - KS < 0) ? 14'sd0 : w_s - KS;
    end else begin
      j0_c = c_s - KS + 14'sd1;
    end
  end
  assign burst_ok = ~i0_c[13] & ~j0_c[13];

  // Advance the source counters on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        if (last_row) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_r + 12'd1;
          slot_r <= (int'(slot_r) == KSIZE - 1) ? '0 : slot_r + SW'(1);
        end
      end else begin
        col_r <= col_r + 11'd1;
      end
    end
  end

  // Burst bounds and per-pixel position
  logic [11:0]   i0_r, i1_r, i_r, q_r;
  logic [10:0]   j0_r, j1_r, j_r;
  logic [SW-1:0] row_slot_r, win_slot_r, ra_r, rb_r;
  logic [36:0]   mod_prod;
  logic [14:0]   qk;

  assign mod_prod = 37'(i0_r) * 37'(RECIP);
  assign qk       = 15'(q_r) * 15'(KSIZE);

  // Line store
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   rdata;
  logic [SW-1:0] rd_slot;
  logic [10:0]   rd_col;

  assign mem_we = in_acc & (int'(col_r) < MAX_WIDTH);
  assign waddr  = AW'(slot_r) * AW'(MAX_WIDTH) + AW'(col_r);
  assign rd_slot = (state_r == S_BRD) ? win_slot_r : row_slot_r;
  assign rd_col  = (state_r == S_BRD) ? j_r + 11'(rb_r) : j_r;
  assign raddr  = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col);

  ccpb_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata ({in_data.blue_in, in_data.green_in, in_data.red_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Circle test terms
  logic signed [13:0] i_s, j_s, di, dj;
  logic        [27:0] di2_r, dj2_r, rr_r;
  logic               pix_black, in_circle, fits;

  assign i_s       = 14'(i_r);
  assign j_s       = 14'(j_r);
  assign di        = i_s - (h_s >>> 1);
  assign dj        = j_s - (w_s >>> 1);
  assign pix_black = (i_s >= h_s - 14'sd1) | (j_s >= w_s - 14'sd1);
  assign in_circle = (di2_r + dj2_r) <= rr_r;
  assign fits      = (i_s <= h_s - KS) & (j_s <= w_s - KS);

  // Contrast and brightness with overflow or underflow to white
  function automatic logic [7:0] contrast_ch(input logic [7:0] ch,
                                             input logic signed [8:0] k,
                                             input logic signed [10:0] b);
    logic signed [19:0] v;
    v = 20'(signed'({1'b0, ch})) * 20'(k) + 20'(b);
    if (v < 0 || v > 20'sd255) return 8'(SAT_MAX);
    return v[7:0];
  endfunction

  // Blur accumulation and division by the total weight
  logic              rd_vld_r;
  logic [2:0]        wt_d_r, wt;
  logic [SUMW-1:0]   acc_r [3];
  logic [QPW-1:0]    qprod [3];
  logic [7:0]        quot [3];
  logic [23:0]       pix_r;
  logic              last_tap, out_acc, last_pix;

  assign wt       = 3'(pyr_weight(KSIZE, int'(ra_r), int'(rb_r)));
  assign last_tap = (int'(ra_r) == KSIZE - 1) & (int'(rb_r) == KSIZE - 1);

  // Divide by reciprocal multiplication, exact over the window sum range
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qprod[c] = QPW'(acc_r[c]) * QPW'(TOT_RECIP);
      quot[c]  = qprod[c][TOT_RSH+7:TOT_RSH];
    end
  end

  assign out_valid = (state_r == S_EMIT);
  assign out_acc   = out_valid & ~out_stall;
  assign last_pix  = (i_r == i1_r) & (j_r == j1_r);

  assign out_data.out_row   = i_r;
  assign out_data.out_col   = j_r;
  assign out_data.red_out   = pix_r[7:0];
  assign out_data.green_out = pix_r[15:8];
  assign out_data.blue_out  = pix_r[23:16];
  assign out_data.run_end   = last_pix;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && burst_ok) state_nxt = S_MOD;
      S_MOD:   state_nxt = S_SLOT;
      S_SLOT:  state_nxt = S_PIX;
      S_PIX:   state_nxt = pix_black ? S_EMIT : S_DEC;
      S_DEC: begin
        priority if (in_circle) state_nxt = S_CAPP;
        else if (fits)          state_nxt = S_BRD;
        else                    state_nxt = S_EMIT;
      end
      S_CAPP:  state_nxt = S_EMIT;
      S_BRD:   if (last_tap) state_nxt = S_BLAST;
      S_BLAST: state_nxt = S_DIV;
      S_DIV:   state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_acc) state_nxt = last_pix ? S_IDLE : S_PIX;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_BRD);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    wt_d_r <= wt;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          i0_r <= i0_c[11:0];
          i1_r <= last_row ? 12'(h_s - 14'sd1) : i0_c[11:0];
          j0_r <= j0_c[10:0];
          j1_r <= last_col ? 11'(w_s - 14'sd1) : j0_c[10:0];
        end
      end
      S_MOD: q_r <= mod_prod[35:24];
      S_SLOT: begin
        row_slot_r <= SW'(15'(i0_r) - qk);
        i_r        <= i0_r;
        j_r        <= j0_r;
      end
      S_PIX: begin
        pix_r <= '0;
        di2_r <= 28'(di * di);
        dj2_r <= 28'(dj * dj);
        rr_r  <= 28'(radius_r) * 28'(radius_r);
      end
      S_DEC: begin
        win_slot_r <= row_slot_r;
        ra_r       <= '0;
        rb_r       <= '0;
        for (int c = 0; c < 3; c++) acc_r[c] <= '0;
      end
      S_CAPP: begin
        pix_r <= {contrast_ch(rdata[23:16], contrast_r, bright_r),
                  contrast_ch(rdata[15:8], contrast_r, bright_r),
                  contrast_ch(rdata[7:0], contrast_r, bright_r)};
      end
      S_BRD: begin
        if (int'(rb_r) == KSIZE - 1) begin
          rb_r       <= '0;
          ra_r       <= ra_r + SW'(1);
          win_slot_r <= (int'(win_slot_r) == KSIZE - 1) ? '0 : win_slot_r + SW'(1);
        end else begin
          rb_r <= rb_r + SW'(1);
        end
      end
      S_DIV: begin
        pix_r <= {quot[2], quot[1], quot[0]};
      end
      S_EMIT: begin
        if (out_acc && !last_pix) begin
          if (j_r == j1_r) begin
            j_r        <= j0_r;
            i_r        <= i_r + 12'd1;
            row_slot_r <= (int'(row_slot_r) == KSIZE - 1) ? '0 : row_slot_r + SW'(1);
          end else begin
            j_r <= j_r + 11'd1;
          end
        end
      end
      default: ;
    endcase
    // Accumulate each window tap in the cycle after its read
    if (rd_vld_r && (state_r == S_BRD || state_r == S_BLAST)) begin
      acc_r[0] <= acc_r[0] + SUMW'(rdata[7:0] * wt_d_r);
      acc_r[1] <= acc_r[1] + SUMW'(rdata[15:8] * wt_d_r);
      acc_r[2] <= acc_r[2] + SUMW'(rdata[23:16] * wt_d_r);
    end
  end

`ifndef SYNTHESIS
  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && burst_ok) |=> (state_r == S_MOD))
    else $error("burst did not start after accepted pixel");

  a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.run_end) |=> (state_r == S_IDLE))
    else $error("block busy after last result of a pixel");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(slot_r) < KSIZE))
    else $error("line-store slot out of range");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLAST) |=> (acc_r[0] <= SUMW'(SAT_MAX * TOT)))
    else $error("window sum exceeds bound");
`endif

endmodule

`default_nettype wire

[hdl/ccpb_ram.sv]
// ----------------------------------------------------------------------------
// ccpb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[tb/circle_contrast_pyramid_blur_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_contrast_pyramid_blur_tb
// Streams whole frames of random and extreme pixels through the filter under
// several geometries and contrast settings, predicts every output pixel and
// its burst marker, and checks each output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_contrast_pyramid_blur_tb;
  import ccpb_pkg::*;

  localparam int K         = KSIZE_DEF;
  localparam int MAXW      = MAX_WIDTH_DEF;
  localparam int IDLE_WAIT = 60;
  localparam int WD_LIMIT  = 20000;
  localparam int N_ITEMS   = 320;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pix_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  pix_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  circle_contrast_pyramid_blur dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  pix_in_t            rows_buf [K*MAXW];
  logic [12:0]        img_h;
  logic [11:0]        img_w;
  logic [12:0]        circ_rad;
  logic signed [8:0]  gain;
  logic signed [10:0] offset;
  int                 cur_row;
  int                 cur_col;

  pix_out_t pending_pix[$];
  int       n_errors;
  int       n_pixels_in;
  int       n_pixels_out;
  int       n_frames;
  int       quiet_cycles;
  bit       calm;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random back-pressure on the output side
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 12);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > WD_LIMIT) begin
      $display("%0t: watchdog expired, %0d pixels still pending", $time, pending_pix.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check each output transaction against the oldest predicted pixel
  always @(posedge clk) begin
    pix_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_pixels_out++;
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected pixel %p", $time, out_data);
        n_errors++;
      end else begin
        e = pending_pix.pop_front();
        if (out_data.out_row !== e.out_row) begin
          $display("%0t: out_row exp %0d got %0d", $time, e.out_row, out_data.out_row);
          n_errors++;
        end
        if (out_data.out_col !== e.out_col) begin
          $display("%0t: out_col exp %0d got %0d", $time, e.out_col, out_data.out_col);
          n_errors++;
        end
        if (out_data.red_out !== e.red_out) begin
          $display("%0t: red (%0d,%0d) exp %0d got %0d", $time, e.out_row, e.out_col,
                   e.red_out, out_data.red_out);
          n_errors++;
        end
        if (out_data.green_out !== e.green_out) begin
          $display("%0t: green (%0d,%0d) exp %0d got %0d", $time, e.out_row, e.out_col,
                   e.green_out, out_data.green_out);
          n_errors++;
        end
        if (out_data.blue_out !== e.blue_out) begin
          $display("%0t: blue (%0d,%0d) exp %0d got %0d", $time, e.out_row, e.out_col,
                   e.blue_out, out_data.blue_out);
          n_errors++;
        end
        if (out_data.run_end !== e.run_end) begin
          $display("%0t: run_end (%0d,%0d) exp %0d got %0d", $time, e.out_row, e.out_col,
                   e.run_end, out_data.run_end);
          n_errors++;
        end
      end
    end
  end

  function automatic int eff_height();
    if (img_h < 2) return 2;
    if (img_h > 4096) return 4096;
    return int'(img_h);
  endfunction

  function automatic int eff_width();
    if (img_w < 2) return 2;
    if (img_w > MAXW) return MAXW;
    return int'(img_w);
  endfunction

  function automatic logic [7:0] apply_gain(input logic [7:0] ch);
    int v;
    v = int'(ch) * int'(gain) + int'(offset);
    if (v < 0 || v > SAT_MAX) return 8'(SAT_MAX);
    return v[7:0];
  endfunction

  // Compute one output pixel from the line buffer
  function automatic pix_in_t filtered_pixel(input int i, input int j, input int h,
                                             input int w);
    pix_in_t p;
    longint  ci, cj, di, dj, rr;
    int      sr, sg, sb, tot, wt;
    p = '0;
    ci = h / 2;
    cj = w / 2;
    di = i - ci;
    dj = j - cj;
    rr = circ_rad;
    if (i >= h - 1 || j >= w - 1) return p;
    if (i <= 2 * ci && j <= 2 * cj && di * di + dj * dj <= rr * rr) begin
      p = rows_buf[(i % K) * MAXW + j];
      p.red_in   = apply_gain(p.red_in);
      p.green_in = apply_gain(p.green_in);
      p.blue_in  = apply_gain(p.blue_in);
      return p;
    end
    if (i <= h - K && j <= w - K) begin
      sr = 0; sg = 0; sb = 0; tot = 0;
      for (int a = 0; a < K; a++) begin
        for (int b = 0; b < K; b++) begin
          wt = 1 + ((a < b) ? a : b);
          if (K - 1 - a < wt - 1) wt = K - a;
          if (K - 1 - b < wt - 1) wt = K - b;
          p = rows_buf[((i + a) % K) * MAXW + j + b];
          sr += p.red_in * wt;
          sg += p.green_in * wt;
          sb += p.blue_in * wt;
          tot += wt;
        end
      end
      p.red_in   = 8'(sr / tot);
      p.green_in = 8'(sg / tot);
      p.blue_in  = 8'(sb / tot);
      return p;
    end
    return '0;
  endfunction

  // Store one source pixel and queue the output burst it releases
  function automatic void predict_burst(input pix_in_t px);
    int       h, w, i0, i1, j0, j1;
    bit       lr, lc;
    pix_in_t  q;
    pix_out_t o;
    h = eff_height();
    w = eff_width();
    lr = cur_row >= h - 1;
    lc = cur_col >= w - 1;
    if (cur_col < MAXW) rows_buf[(cur_row % K) * MAXW + cur_col] = px;
    if (lr) begin
      i0 = (h - K < 0) ? 0 : h - K;
      i1 = h - 1;
    end else begin
      i0 = cur_row - K + 1;
      i1 = i0;
    end
    if (lc) begin
      j0 = (w - K < 0) ? 0 : w - K;
      j1 = w - 1;
    end else begin
      j0 = cur_col - K + 1;
      j1 = j0;
    end
    if (i0 >= 0 && j0 >= 0) begin
      for (int i = i0; i <= i1; i++) begin
        for (int j = j0; j <= j1; j++) begin
          q = filtered_pixel(i, j, h, w);
          o.out_row   = 12'(i);
          o.out_col   = 11'(j);
          o.red_out   = q.red_in;
          o.green_out = q.green_in;
          o.blue_out  = q.blue_in;
          o.run_end   = (i == i1 && j == j1);
          pending_pix.push_back(o);
        end
      end
    end
    if (lc) begin
      cur_col = 0;
      cur_row = lr ? 0 : ((cur_row + 1) & 12'hFFF);
    end else begin
      cur_col = (cur_col + 1) & 11'h7FF;
    end
  endfunction

  // Optionally idle, then drive one pixel transaction and hold it until taken
  task automatic send_pixel(input pix_in_t px);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_burst(px);
    n_pixels_in++;
  endtask

  // Wait until every predicted pixel has left the block
  task automatic drain();
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEIGHT:     img_h    = 13'(value);
      REG_WIDTH:      img_w    = 12'(value);
      REG_RADIUS:     circ_rad = 13'(value);
      REG_CONTRAST:   gain     = 9'(value);
      REG_BRIGHTNESS: offset   = 11'(value);
      default: ;
    endcase
  endtask

  // Program a setting and stream whole frames; style 0 random, 1 extremes
  task automatic run_frames(input int h, input int w, input int rad, input int con,
                            input int bri, input int frames, input int style);
    pix_in_t px;
    int      cnt;
    reg_write(REG_HEIGHT, h);
    reg_write(REG_WIDTH, w);
    reg_write(REG_RADIUS, rad);
    reg_write(REG_CONTRAST, con);
    reg_write(REG_BRIGHTNESS, bri);
    cnt = eff_height() * eff_width() * frames;
    for (int n = 0; n < cnt; n++) begin
      if (style == 1) px = (n % 3 == 0) ? 24'hFFFFFF : (n % 3 == 1) ? 24'h000000 : 24'hFF00FF;
      else px = 24'($urandom);
      send_pixel(px);
    end
    in_valid <= 1'b0;
    n_frames += frames;
    drain();
  endtask

  task automatic test_directed();
    // full circle, saturating gains, extreme pixels
    run_frames(5, 5, 8191, 255, 1023, 1, 1);
    run_frames(5, 5, 8191, -255, -1024, 1, 1);
    // blur where the window fits, one-pixel circle at the centre, then frame wrap
    run_frames(6, 7, 0, 1, 0, 2, 1);
  endtask

  task automatic test_geometry_limits();
    run_frames(0, 0, 1, 2, 5, 1, 0);
    run_frames(1, 1, 0, 1, 0, 1, 0);
    run_frames(2, 2, 0, 1, 0, 1, 0);
    run_frames(4, 3, 1, 3, -100, 1, 0);
  endtask

  task automatic test_random_frames();
    int con, bri;
    while (n_pixels_in < N_ITEMS) begin
      calm = ($urandom_range(5) == 0);
      con = ($urandom_range(1)) ? $urandom_range(0, 3) : $urandom_range(0, 510) - 255;
      bri = ($urandom_range(1)) ? $urandom_range(0, 60) - 30 : $urandom_range(0, 2047) - 1024;
      run_frames($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(0, 8),
                 con, bri, 1, 0);
    end
    calm = 1'b0;
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    n_errors     = 0;
    n_pixels_in  = 0;
    n_pixels_out = 0;
    n_frames     = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    img_h        = RST_HEIGHT;
    img_w        = RST_WIDTH;
    circ_rad     = RST_RADIUS;
    gain         = RST_CONTRAST;
    offset       = RST_BRIGHTNESS;
    cur_row      = 0;
    cur_col      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_geometry_limits();
    test_random_frames();

    $display("Covered %0d frames: %0d source pixels in, %0d output pixels checked.",
             n_frames, n_pixels_in, n_pixels_out);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
